/* rtl/mbe_pkg.sv */
`timescale 1ns / 1ps
// shared widths, register map and reset values of the mandelbrot pixel core
package mbe_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int INT_BITS       = 4;

  localparam int CFG_SIZE_W  = 13;
  localparam int LIMIT_W     = 16;
  localparam int COUNT_W     = LIMIT_W;
  localparam int GREY_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ITERATION_LIMIT = 2'd2;

  localparam logic [CFG_SIZE_W-1:0] IMAGE_WIDTH_RST     = 13'd1024;
  localparam logic [CFG_SIZE_W-1:0] IMAGE_HEIGHT_RST    = 13'd1024;
  localparam logic [LIMIT_W-1:0]    ITERATION_LIMIT_RST = 16'd500;

endpackage

/* rtl/mandelbrot_escape_time_pixel_core.sv */
`timescale 1ns / 1ps
// top level of the mandelbrot escape-time pixel core with its register port
//
// channel   ports                                   direction
// -------   -------------------------------------   ---------
// in        in_valid/in_ready, pixel column, row    pixel coordinate item in
// out       out_valid/out_ready, count, grey level  result item out
// config    psel/penable/pwrite/paddr/pwdata/...    register writes and reads
//
// front end: the two-lane restoring divider forms c at one quotient bit per
//   cycle and takes a new pixel only after the last one is pushed
// back end: the multiply, sum and update loop runs until the point escapes or
//   reaches the limit, followed by the eight-step grey level divider
// a two-entry queue between them lets the front map the next pixels while
//   the back iterates, and the output register holds a result under stall
// synchronous active-low reset clears control state only, no clearing pass
module mandelbrot_escape_time_pixel_core import mbe_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pixel_column,
  input  logic [COORD_BITS-1:0] in_pixel_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_W-1:0]    out_iteration_count,
  output logic [GREY_W-1:0]     out_grey_level,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ZW = FRAC_BITS + INT_BITS;

  logic [CFG_SIZE_W-1:0] width_r;
  logic [CFG_SIZE_W-1:0] height_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  logic                  push_valid;
  logic                  push_ready;
  logic [ZW-1:0]         push_c_re;
  logic [ZW-1:0]         push_c_im;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [2*ZW-1:0]       pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
      limit_r  <= ITERATION_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:     width_r  <= pwdata[CFG_SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    height_r <= pwdata[CFG_SIZE_W-1:0];
        REG_ITERATION_LIMIT: limit_r  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:     prdata = APB_DATA_W'(width_r);
      REG_IMAGE_HEIGHT:    prdata = APB_DATA_W'(height_r);
      REG_ITERATION_LIMIT: prdata = APB_DATA_W'(limit_r);
      default:             prdata = '0;
    endcase
  end

  mbe_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_column  (in_pixel_column),
    .in_pixel_row     (in_pixel_row),
    .cfg_image_width  (width_r),
    .cfg_image_height (height_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_c_re        (push_c_re),
    .push_c_im        (push_c_im)
  );

  mbe_queue #(
    .WIDTH (2 * ZW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_c_im, push_c_re}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  mbe_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_c_re            (pop_data[ZW-1:0]),
    .pop_c_im            (pop_data[2*ZW-1:ZW]),
    .cfg_iteration_limit (limit_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count),
    .out_grey_level      (out_grey_level)
  );

endmodule

/* rtl/mbe_front.sv */
`timescale 1ns / 1ps
// front end: clamps the pixel and maps it to the point c by long division
module mbe_front import mbe_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_BITS-1:0]         in_pixel_column,
  input  logic [COORD_BITS-1:0]         in_pixel_row,
  input  logic [CFG_SIZE_W-1:0]         cfg_image_width,
  input  logic [CFG_SIZE_W-1:0]         cfg_image_height,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [FRAC_BITS+INT_BITS-1:0] push_c_re,
  output logic [FRAC_BITS+INT_BITS-1:0] push_c_im
);

  localparam int LANES  = 2;
  localparam int SW     = COORD_BITS + 1;
  localparam int EXT_W  = (CFG_SIZE_W > SW) ? CFG_SIZE_W : SW;
  localparam int ZW     = FRAC_BITS + INT_BITS;
  localparam int QW     = FRAC_BITS + 2;
  localparam int STEPS  = FRAC_BITS + 2;
  localparam int STEP_W = $clog2(STEPS + 1);

  typedef enum logic [2:0] {F_IDLE, F_PREP, F_DIV, F_FIN, F_PUSH} fstate_t;

  fstate_t            state_r;
  logic [STEP_W-1:0]  step_r;
  logic [SW-1:0]      pos_r  [LANES];
  logic [SW-1:0]      rem_r  [LANES];
  logic [QW-1:0]      q_r    [LANES];
  logic               neg_r  [LANES];
  logic [ZW-1:0]      c_r    [LANES];

  logic [SW-1:0]      size_s    [LANES];
  logic [SW-1:0]      pos_in_s  [LANES];
  logic [SW-1:0]      clamp_s   [LANES];
  logic [SW-1:0]      twice_s   [LANES];
  logic               neg_s     [LANES];
  logic [SW-1:0]      d_s       [LANES];
  logic [SW:0]        cand_s    [LANES];
  logic               ge_s      [LANES];
  logic [SW-1:0]      rem_nxt   [LANES];
  logic [ZW-1:0]      q_ext_s   [LANES];
  logic [ZW-1:0]      c_nxt     [LANES];
  logic               first_s;

  function automatic logic [SW-1:0] eff_size(input logic [CFG_SIZE_W-1:0] v);
    logic [EXT_W-1:0] ve;
    logic [EXT_W-1:0] maxs;
    ve   = EXT_W'(v);
    maxs = EXT_W'(1) << COORD_BITS;
    if (ve == '0) begin
      return SW'(1);
    end else if (ve > maxs) begin
      return SW'(maxs);
    end else begin
      return SW'(ve);
    end
  endfunction

  assign size_s[0]   = eff_size(cfg_image_width);
  assign size_s[1]   = eff_size(cfg_image_height);
  assign pos_in_s[0] = {1'b0, in_pixel_column};
  assign pos_in_s[1] = {1'b0, in_pixel_row};
  assign first_s     = (step_r == STEP_W'(STEPS));

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      clamp_s[i] = (pos_in_s[i] >= size_s[i]) ? size_s[i] - SW'(1) : pos_in_s[i];
      twice_s[i] = {pos_r[i][SW-2:0], 1'b0};
      neg_s[i]   = twice_s[i] < size_s[i];
      d_s[i]     = neg_s[i] ? size_s[i] - twice_s[i] : twice_s[i] - size_s[i];
      cand_s[i]  = first_s ? {1'b0, rem_r[i]} : {rem_r[i], 1'b0};
      ge_s[i]    = cand_s[i] >= {1'b0, size_s[i]};
      rem_nxt[i] = ge_s[i] ? SW'(cand_s[i] - {1'b0, size_s[i]}) : cand_s[i][SW-1:0];
      q_ext_s[i] = ZW'(q_r[i]);
      // floor for the negative side: -(q + 1) is ~q
      if (neg_r[i]) begin
        c_nxt[i] = (rem_r[i] != '0) ? ~q_ext_s[i] : ~q_ext_s[i] + ZW'(1);
      end else begin
        c_nxt[i] = q_ext_s[i];
      end
    end
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_c_re  = c_r[0];
  assign push_c_im  = c_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < LANES; i++) begin
              pos_r[i] <= clamp_s[i];
            end
            state_r <= F_PREP;
          end
        end
        F_PREP: begin
          for (int i = 0; i < LANES; i++) begin
            rem_r[i] <= d_s[i];
            neg_r[i] <= neg_s[i];
            q_r[i]   <= '0;
          end
          step_r  <= STEP_W'(STEPS);
          state_r <= F_DIV;
        end
        F_DIV: begin
          for (int i = 0; i < LANES; i++) begin
            rem_r[i] <= rem_nxt[i];
            q_r[i]   <= {q_r[i][QW-2:0], ge_s[i]};
          end
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            state_r <= F_FIN;
          end
        end
        F_FIN: begin
          for (int i = 0; i < LANES; i++) begin
            c_r[i] <= c_nxt[i];
          end
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/mbe_queue.sv */
`timescale 1ns / 1ps
// short register queue between the front end and the iteration engine
module mbe_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= wr_data;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/mbe_iter.sv */
`timescale 1ns / 1ps
// back end: z = z^2 + c iteration, grey level division and output register
module mbe_iter import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [FRAC_BITS+INT_BITS-1:0] pop_c_re,
  input  logic [FRAC_BITS+INT_BITS-1:0] pop_c_im,
  input  logic [LIMIT_W-1:0]            cfg_iteration_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COUNT_W-1:0]            out_iteration_count,
  output logic [GREY_W-1:0]             out_grey_level
);

  localparam int ZW      = FRAC_BITS + INT_BITS;
  localparam int LO      = ZW / 2;
  localparam int HI      = ZW - LO;
  localparam int PW      = 2 * ZW;
  localparam int HH_W    = 2 * HI;
  localparam int HL_W    = HI + LO + 1;
  localparam int LL_W    = 2 * LO;
  localparam int ESC_BIT = 2 * FRAC_BITS + 2;
  localparam int N_W     = COUNT_W + GREY_W;
  localparam int GSTEP_W = $clog2(GREY_W + 1);

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SUM, B_UPD, B_GPREP, B_GDIV, B_DONE
  } bstate_t;

  bstate_t                  state_r;
  logic [ZW-1:0]            cr_r;
  logic [ZW-1:0]            ci_r;
  logic [ZW-1:0]            zr_r;
  logic [ZW-1:0]            zi_r;
  logic [COUNT_W-1:0]       count_r;

  logic signed [HH_W-1:0]   rr_hh_r, ii_hh_r, ri_hh_r;
  logic signed [HL_W-1:0]   rr_hl_r, ii_hl_r, ri_hl_r, ri_lh_r;
  logic [LL_W-1:0]          rr_ll_r, ii_ll_r, ri_ll_r;
  logic [PW-1:0]            sr_r, si_r, x_r;

  logic [COUNT_W-1:0]       grem_r;
  logic [GREY_W-1:0]        nlo_r;
  logic [GREY_W-1:0]        gq_r;
  logic [GSTEP_W-1:0]       gstep_r;

  logic                     out_valid_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic [GREY_W-1:0]        out_grey_r;

  logic signed [HI-1:0]     zr_h, zi_h;
  logic signed [LO:0]       zr_l, zi_l;
  logic [LO-1:0]            zr_lu, zi_lu;
  logic [PW-1:0]            sr_nxt, si_nxt, x_nxt;
  logic [PW-1:0]            sum_s, diff_s;
  logic                     esc_s;
  logic [ZW-1:0]            zr_nxt, zi_nxt;
  logic [COUNT_W-1:0]       count_nxt;
  logic [LIMIT_W-1:0]       limit_eff;
  logic [N_W-1:0]           n_s;
  logic [COUNT_W:0]         gcand_s;
  logic                     gge_s;
  logic [COUNT_W-1:0]       grem_nxt;
  logic                     out_free;

  assign limit_eff = (cfg_iteration_limit == '0) ? LIMIT_W'(1) : cfg_iteration_limit;

  // signed split of z for the partial products
  assign zr_h  = zr_r[ZW-1:LO];
  assign zi_h  = zi_r[ZW-1:LO];
  assign zr_lu = zr_r[LO-1:0];
  assign zi_lu = zi_r[LO-1:0];
  assign zr_l  = {1'b0, zr_lu};
  assign zi_l  = {1'b0, zi_lu};

  assign sr_nxt = (PW'(rr_hh_r) << (2 * LO)) + (PW'(rr_hl_r) << (LO + 1)) + PW'(rr_ll_r);
  assign si_nxt = (PW'(ii_hh_r) << (2 * LO)) + (PW'(ii_hl_r) << (LO + 1)) + PW'(ii_ll_r);
  assign x_nxt  = (PW'(ri_hh_r) << (2 * LO)) + ((PW'(ri_hl_r) + PW'(ri_lh_r)) << LO)
                + PW'(ri_ll_r);

  assign sum_s     = sr_r + si_r;
  assign diff_s    = sr_r - si_r;
  assign esc_s     = |sum_s[PW-1:ESC_BIT];
  assign zr_nxt    = diff_s[FRAC_BITS +: ZW] + cr_r;
  assign zi_nxt    = x_r[FRAC_BITS-1 +: ZW] + ci_r;
  assign count_nxt = count_r + COUNT_W'(1);

  // 255 * count
  assign n_s      = {count_r, GREY_W'(0)} - N_W'(count_r);
  assign gcand_s  = {grem_r, nlo_r[GREY_W-1]};
  assign gge_s    = gcand_s >= {1'b0, limit_eff};
  assign grem_nxt = gge_s ? COUNT_W'(gcand_s - {1'b0, limit_eff}) : gcand_s[COUNT_W-1:0];

  assign out_free            = !out_valid_r || out_ready;
  assign pop_ready           = (state_r == B_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_grey_level      = out_grey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      gstep_r     <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            cr_r    <= pop_c_re;
            ci_r    <= pop_c_im;
            zr_r    <= pop_c_re;
            zi_r    <= pop_c_im;
            count_r <= '0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          rr_hh_r <= HH_W'(zr_h) * HH_W'(zr_h);
          rr_hl_r <= HL_W'(zr_h) * HL_W'(zr_l);
          rr_ll_r <= LL_W'(zr_lu) * LL_W'(zr_lu);
          ii_hh_r <= HH_W'(zi_h) * HH_W'(zi_h);
          ii_hl_r <= HL_W'(zi_h) * HL_W'(zi_l);
          ii_ll_r <= LL_W'(zi_lu) * LL_W'(zi_lu);
          ri_hh_r <= HH_W'(zr_h) * HH_W'(zi_h);
          ri_hl_r <= HL_W'(zr_h) * HL_W'(zi_l);
          ri_lh_r <= HL_W'(zi_h) * HL_W'(zr_l);
          ri_ll_r <= LL_W'(zr_lu) * LL_W'(zi_lu);
          state_r <= B_SUM;
        end
        B_SUM: begin
          sr_r    <= sr_nxt;
          si_r    <= si_nxt;
          x_r     <= x_nxt;
          state_r <= B_UPD;
        end
        B_UPD: begin
          if (esc_s) begin
            state_r <= B_GPREP;
          end else begin
            zr_r    <= zr_nxt;
            zi_r    <= zi_nxt;
            count_r <= count_nxt;
            state_r <= (count_nxt == limit_eff) ? B_GPREP : B_MUL;
          end
        end
        B_GPREP: begin
          grem_r  <= n_s[N_W-1:GREY_W];
          nlo_r   <= n_s[GREY_W-1:0];
          gq_r    <= '0;
          gstep_r <= GSTEP_W'(GREY_W);
          state_r <= B_GDIV;
        end
        B_GDIV: begin
          grem_r  <= grem_nxt;
          nlo_r   <= {nlo_r[GREY_W-2:0], 1'b0};
          gq_r    <= {gq_r[GREY_W-2:0], gge_s};
          gstep_r <= gstep_r - GSTEP_W'(1);
          if (gstep_r == GSTEP_W'(1)) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_count_r <= count_r;
            out_grey_r  <= gq_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the mandelbrot escape-time pixel core
module tb_top;
  import mbe_pkg::*;

  localparam int CB       = COORD_BITS_DEF;
  localparam int FB       = FRAC_BITS_DEF;
  localparam int MAX_SIZE = 1 << CB;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [CB-1:0] col;
    logic [CB-1:0] row;
  } pixel_t;

  typedef struct {
    logic [CB-1:0]      col;
    logic [CB-1:0]      row;
    logic [COUNT_W-1:0] count;
    logic [GREY_W-1:0]  grey;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CB-1:0] in_pixel_column = '0;
  logic [CB-1:0] in_pixel_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COUNT_W-1:0] out_iteration_count;
  logic [GREY_W-1:0] out_grey_level;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic [CFG_SIZE_W-1:0] cur_width = IMAGE_WIDTH_RST;
  logic [CFG_SIZE_W-1:0] cur_height = IMAGE_HEIGHT_RST;
  logic [LIMIT_W-1:0] cur_limit = ITERATION_LIMIT_RST;

  pixel_t pending_pixels[$];
  pixel_result_t expected_results[$];
  pixel_t next_px;
  pixel_result_t want;
  bit gaps_on = 1'b1;
  int n_errors = 0;
  int n_checked = 0;
  int n_settings = 0;
  int n_inside = 0;
  int n_outside = 0;

  mandelbrot_escape_time_pixel_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_column     (in_pixel_column),
    .in_pixel_row        (in_pixel_row),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count),
    .out_grey_level      (out_grey_level),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  // floor((2p - s) * 2^(F+1) / s)
  function automatic logic signed [63:0] fixed_coord(int unsigned p, int unsigned s);
    longint num;
    longint sz;
    sz = s;
    num = (2 * longint'(p) - sz) <<< (FB + 1);
    if (num >= 0) return num / sz;
    return -((-num + sz - 1) / sz);
  endfunction

  function automatic pixel_result_t escape_time(logic [CB-1:0] col, logic [CB-1:0] row);
    int unsigned w;
    int unsigned h;
    int unsigned lim;
    int unsigned x;
    int unsigned y;
    int unsigned n;
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    logic signed [63:0] zr;
    logic signed [63:0] zi;
    logic signed [63:0] zr_next;
    logic signed [127:0] sr;
    logic signed [127:0] si;
    logic signed [127:0] prod_ri;
    logic signed [127:0] four;
    pixel_result_t r;
    w = cur_width == 0 ? 1 : (cur_width > MAX_SIZE ? MAX_SIZE : cur_width);
    h = cur_height == 0 ? 1 : (cur_height > MAX_SIZE ? MAX_SIZE : cur_height);
    lim = cur_limit == 0 ? 1 : cur_limit;
    x = col >= w ? w - 1 : col;
    y = row >= h ? h - 1 : row;
    cr = fixed_coord(x, w);
    ci = fixed_coord(y, h);
    zr = cr;
    zi = ci;
    four = 128'sd1 <<< (2 * FB + 2);
    n = 0;
    while (n < lim) begin
      sr = 128'(zr) * 128'(zr);
      si = 128'(zi) * 128'(zi);
      if (sr + si >= four) break;
      prod_ri = 128'(zr) * 128'(zi);
      zr_next = 64'(((sr - si) >>> FB) + 128'(cr));
      zi = 64'((prod_ri >>> (FB - 1)) + 128'(ci));
      zr = zr_next;
      n++;
    end
    r.col = col;
    r.row = row;
    r.count = n[COUNT_W-1:0];
    r.grey = GREY_W'((255 * n) / lim);
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(escape_time(in_pixel_column, in_pixel_row));
      end
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() > 0 && !(gaps_on && $urandom_range(99) < 38)) begin
          next_px = pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_pixel_column <= next_px.col;
          in_pixel_row <= next_px.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item, count %0d grey %0d", $time,
                   out_iteration_count, out_grey_level);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (want.grey == 8'd255) n_inside++;
          if (want.count == 0) n_outside++;
          if (out_iteration_count !== want.count) begin
            $display("%0t: pixel (%0d,%0d) count expected %0d got %0d", $time,
                     want.col, want.row, want.count, out_iteration_count);
            n_errors++;
          end
          if (out_grey_level !== want.grey) begin
            $display("%0t: pixel (%0d,%0d) grey expected %0d got %0d", $time,
                     want.col, want.row, want.grey, out_grey_level);
            n_errors++;
          end
        end
      end
      out_ready <= !(gaps_on && $urandom_range(99) < 38);
    end
  end

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: cur_width = data[CFG_SIZE_W-1:0];
      REG_IMAGE_HEIGHT: cur_height = data[CFG_SIZE_W-1:0];
      REG_ITERATION_LIMIT: cur_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [APB_DATA_W-1:0] w, logic [APB_DATA_W-1:0] h,
                            logic [APB_DATA_W-1:0] lim);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_ITERATION_LIMIT, lim);
    n_settings++;
  endtask

  task automatic add_pixel(int unsigned col, int unsigned row);
    pixel_t p;
    p.col = col[CB-1:0];
    p.row = row[CB-1:0];
    pending_pixels.push_back(p);
  endtask

  // half the pixels inside the image, half anywhere in the coordinate range
  task automatic add_random(int n, int unsigned w, int unsigned h);
    repeat (n) begin
      if ($urandom_range(1)) add_pixel($urandom_range(w - 1), $urandom_range(h - 1));
      else add_pixel($urandom, $urandom);
    end
  endtask

  // wait until every item is taken and every result is back
  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned lim;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: corners, center, real-axis points, clamped coordinates
    n_settings = 1;
    add_pixel(0, 0);
    add_pixel(512, 512);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(256, 512);
    add_pixel(384, 512);
    add_pixel(640, 512);
    add_pixel(1023, 511);
    add_pixel(12'hAAA, 12'h155);
    add_pixel(12'h155, 12'h2AA);
    drain();

    // zero sizes and zero limit
    set_config(0, 0, 0);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(1, 2);
    drain();

    // oversized width, largest size, limit of one
    set_config(8191, MAX_SIZE, 1);
    add_pixel(2048, 2048);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_random(12, MAX_SIZE, MAX_SIZE);
    drain();

    // upper bits beyond the fields are dropped, unused register has no effect
    set_config(32'hFFFF_0003, 32'h0001_2005, 32'hABCD_0010);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    add_random(12, 3, 5);
    drain();

    // largest limit
    set_config(1024, 1024, 65535);
    add_pixel(512, 512);
    add_pixel(640, 512);
    add_pixel(0, 0);
    drain();

    for (int k = 0; k < 8; k++) begin
      case (k % 4)
        0: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(1, 16);
        end
        1: begin
          w = $urandom_range(1, MAX_SIZE);
          h = $urandom_range(1, MAX_SIZE);
        end
        2: begin
          w = MAX_SIZE;
          h = MAX_SIZE;
        end
        default: begin
          w = $urandom_range(17, 300);
          h = $urandom_range(17, 300);
        end
      endcase
      lim = (k == 6) ? $urandom_range(100, 255) : $urandom_range(1, 48);
      gaps_on = (k != 3);
      set_config(w, h, lim);
      add_random(150, w, h);
      drain();
    end
    gaps_on = 1'b1;

    $display("%0d pixels checked over %0d register settings", n_checked, n_settings);
    $display("%0d ran to the limit, %0d escaped before the first iteration",
             n_inside, n_outside);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
